// ===== src/dq_pkg.sv =====
package dq_pkg;

  localparam int OP_W  = 3;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;
  localparam int LEN_W = 7;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_LENGTH     = 3'd4;
  localparam logic [OP_W-1:0] OP_LIST       = 3'd5;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]         opcode;
    logic signed [VAL_W-1:0] value;
  } dq_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] item_value;
    logic [ST_W-1:0]         status;
    logic [LEN_W-1:0]        length;
    logic                    last;
  } dq_out_t;

  typedef struct packed {
    logic            push_front;
    logic            push_back;
    logic            pop_front;
    logic            pop_back;
    logic            list_start;
    logic            list_next;
    logic            emit_now;
    logic [ST_W-1:0] emit_status;
    logic            emit_read;
    logic            emit_last;
  } dq_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic list_end;
  } dq_stat_t;

endpackage

// ===== src/dq_ctrl.sv =====
module dq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [2:0]       opcode,
  input  dq_pkg::dq_stat_t stat,
  output logic             busy,
  output dq_pkg::dq_ctl_t  ctl
);
  import dq_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_POP, S_LIST} state_t;

  state_t state, state_next;
  logic   accept;

  assign busy   = rst || (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    ctl         = '0;
    ctl.emit_status = ST_OK;
    state_next  = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          ctl.emit_last = 1'b1;
          unique case (opcode) inside
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              ctl.emit_now = 1'b1;
              if (stat.full) begin
                ctl.emit_status = ST_FULL;
              end else begin
                ctl.push_front = (opcode == OP_PUSH_FRONT);
                ctl.push_back  = (opcode == OP_PUSH_BACK);
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (stat.empty) begin
                ctl.emit_now    = 1'b1;
                ctl.emit_status = ST_EMPTY;
              end else begin
                ctl.pop_front = (opcode == OP_POP_FRONT);
                ctl.pop_back  = (opcode == OP_POP_BACK);
                state_next    = S_POP;
              end
            end
            OP_LIST: begin
              if (stat.empty) begin
                ctl.emit_now    = 1'b1;
                ctl.emit_status = ST_EMPTY;
              end else begin
                ctl.list_start = 1'b1;
                state_next     = S_LIST;
              end
            end
            default: begin
              ctl.emit_now = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        ctl.emit_read = 1'b1;
        ctl.emit_last = 1'b1;
        state_next    = S_IDLE;
      end
      S_LIST: begin
        ctl.emit_read = 1'b1;
        ctl.emit_last = stat.list_end;
        if (stat.list_end) begin
          state_next = S_IDLE;
        end else begin
          ctl.list_next = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/dq_datapath.sv =====
module dq_datapath #(
  parameter int DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  dq_pkg::dq_in_t   cmd,
  input  dq_pkg::dq_ctl_t  ctl,
  output dq_pkg::dq_stat_t stat,
  output logic             valid,
  output dq_pkg::dq_out_t  result
);
  import dq_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = IW + 1;

  logic signed [VAL_W-1:0] mem [DEPTH];
  logic signed [VAL_W-1:0] rdata;

  logic [IW-1:0] front, front_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] pos;
  logic [IW-1:0] waddr, raddr, front_dec, back_slot, tail_slot, next_slot;
  logic          we, re;

  function automatic logic [IW-1:0] wrap(input logic [SW-1:0] s);
    logic [SW-1:0] d;
    d = (s >= SW'(DEPTH)) ? (s - SW'(DEPTH)) : s;
    return d[IW-1:0];
  endfunction

  assign front_dec = (front == '0) ? IW'(DEPTH - 1) : (front - IW'(1));
  assign back_slot = wrap(SW'(front) + SW'(count));
  assign tail_slot = wrap(SW'(front) + SW'(count) - SW'(1));
  assign next_slot = wrap(SW'(front) + SW'(pos) + SW'(1));

  assign stat.empty    = (count == '0);
  assign stat.full     = (count >= CW'(DEPTH));
  assign stat.list_end = ((pos + CW'(1)) == count);

  assign we    = ctl.push_front || ctl.push_back;
  assign waddr = ctl.push_front ? front_dec : back_slot;
  assign re    = ctl.pop_front || ctl.pop_back || ctl.list_start || ctl.list_next;

  always_comb begin
    if (ctl.pop_back) begin
      raddr = tail_slot;
    end else if (ctl.list_next) begin
      raddr = next_slot;
    end else begin
      raddr = front;
    end
  end

  always_comb begin
    front_next = front;
    count_next = count;
    if (ctl.push_front) begin
      front_next = front_dec;
    end else if (ctl.pop_front) begin
      front_next = wrap(SW'(front) + SW'(1));
    end
    if (we) begin
      count_next = count + CW'(1);
    end else if (ctl.pop_front || ctl.pop_back) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= cmd.value;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
      pos   <= '0;
      valid <= 1'b0;
    end else begin
      front <= front_next;
      count <= count_next;
      valid <= ctl.emit_now || ctl.emit_read;
      if (ctl.list_start) begin
        pos <= '0;
      end else if (ctl.list_next) begin
        pos <= pos + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit_now) begin
      result.item_value <= '0;
      result.status     <= ctl.emit_status;
      result.length     <= LEN_W'(count_next);
      result.last       <= 1'b1;
    end else if (ctl.emit_read) begin
      result.item_value <= rdata;
      result.status     <= ST_OK;
      result.length     <= LEN_W'(count);
      result.last       <= ctl.emit_last;
    end
  end

endmodule

// ===== src/double_ended_queue.sv =====
// Push, length and refused operations give their result in the next cycle; one item per cycle.
// A pop reads the entry memory first: the read data is registered, then the result; busy meanwhile.
// A list gives one result per cycle, each after a registered read; busy until the last.
// The entry memory's read port and its registered read data set the pop and list latency.
// Synchronous reset empties the queue; entry contents are not cleared and need no sweep.
module double_ended_queue #(
  parameter int DEPTH = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  dq_pkg::dq_in_t  cmd,
  output logic            valid,
  output dq_pkg::dq_out_t result
);
  import dq_pkg::*;

  dq_ctl_t  ctl;
  dq_stat_t stat;

  dq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (cmd.opcode),
    .stat   (stat),
    .busy   (busy),
    .ctl    (ctl)
  );

  dq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .ctl    (ctl),
    .stat   (stat),
    .valid  (valid),
    .result (result)
  );

  a_push_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd.opcode == OP_PUSH_FRONT || cmd.opcode == OP_PUSH_BACK))
    |=> (valid && result.last))
    else $error("push item did not give a result in the next cycle");

  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    valid |-> (result.length <= LEN_W'(DEPTH)))
    else $error("length exceeds queue depth");

  a_full_means_depth: assert property (@(posedge clk) disable iff (rst)
    (valid && result.status == ST_FULL) |-> (result.length == LEN_W'(DEPTH)))
    else $error("full status with queue not full");

  a_list_continues: assert property (@(posedge clk) disable iff (rst)
    (valid && !result.last) |=> valid)
    else $error("list stopped before its last item");

endmodule

// ===== bench/tb_double_ended_queue.sv =====
module tb_double_ended_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import dq_pkg::*;

  localparam int DEPTH = 64;
  localparam int RANDOM_ITEMS = 330;
  localparam int DIRECTED_ITEMS = 24;
  localparam logic [OP_W-1:0] OP_BAD_LOW  = 3'd6;
  localparam logic [OP_W-1:0] OP_BAD_HIGH = 3'd7;
  localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

  typedef enum {GROW, SHRINK, MIXED} traffic_mode_t;

  // Software copy of the queue; every accepted item appends its expected results.
  class deque_tracker;
    logic signed [VAL_W-1:0] slot_value [DEPTH];
    int head;
    int fill;
    dq_out_t expected_results [$];
    int items_seen;
    int checked;
    int mismatches;
    int full_refusals;
    int empty_hits;
    int listed;

    function void add_result(logic signed [VAL_W-1:0] v, logic [ST_W-1:0] st, logic lst);
      dq_out_t r;
      r.item_value = v;
      r.status = st;
      r.length = LEN_W'(fill);
      r.last = lst;
      expected_results.push_back(r);
    endfunction

    function void note_command(dq_in_t c);
      logic signed [VAL_W-1:0] v;
      items_seen++;
      case (c.opcode)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (fill >= DEPTH) begin
            full_refusals++;
            add_result('0, ST_FULL, 1'b1);
          end else begin
            if (c.opcode == OP_PUSH_FRONT) begin
              head = (head + DEPTH - 1) % DEPTH;
              slot_value[head] = c.value;
            end else begin
              slot_value[(head + fill) % DEPTH] = c.value;
            end
            fill++;
            add_result('0, ST_OK, 1'b1);
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          if (fill == 0) begin
            empty_hits++;
            add_result('0, ST_EMPTY, 1'b1);
          end else begin
            if (c.opcode == OP_POP_FRONT) begin
              v = slot_value[head];
              head = (head + 1) % DEPTH;
            end else begin
              v = slot_value[(head + fill - 1) % DEPTH];
            end
            fill--;
            add_result(v, ST_OK, 1'b1);
          end
        end
        OP_LENGTH: add_result('0, ST_OK, 1'b1);
        OP_LIST: begin
          if (fill == 0) begin
            empty_hits++;
            add_result('0, ST_EMPTY, 1'b1);
          end else begin
            for (int k = 0; k < fill; k++) begin
              add_result(slot_value[(head + k) % DEPTH], ST_OK, k == fill - 1);
            end
            listed += fill;
          end
        end
        default: add_result('0, ST_OK, 1'b1);
      endcase
    endfunction

    function void check_result(dq_out_t got);
      dq_out_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result with nothing expected: value %0d status %0d length %0d last %0b",
                   $realtime, got.item_value, got.status, got.length, got.last);
        end
      end else begin
        want = expected_results.pop_front();
        checked++;
        if (got.item_value !== want.item_value || got.status !== want.status ||
            got.length !== want.length || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: mismatch: value %0d/%0d status %0d/%0d length %0d/%0d last %0b/%0b",
                     $realtime, got.item_value, want.item_value, got.status, want.status,
                     got.length, want.length, got.last, want.last);
            $display("  (each pair is actual/expected)");
          end
        end
      end
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst;
  logic    start;
  logic    busy;
  dq_in_t  cmd;
  logic    valid;
  dq_out_t result;

  deque_tracker tracker;
  bit quiet;

  logic [OP_W-1:0] directed_ops [DIRECTED_ITEMS] = '{
    OP_LIST, OP_POP_FRONT, OP_POP_BACK, OP_LENGTH, OP_BAD_LOW, OP_BAD_HIGH,
    OP_PUSH_FRONT, OP_PUSH_BACK, OP_PUSH_FRONT, OP_PUSH_BACK, OP_PUSH_FRONT, OP_PUSH_BACK,
    OP_LIST, OP_LENGTH, OP_POP_FRONT, OP_POP_BACK, OP_BAD_HIGH, OP_LIST,
    OP_POP_FRONT, OP_POP_BACK, OP_POP_FRONT, OP_POP_BACK, OP_POP_FRONT, OP_LIST
  };
  logic [VAL_W-1:0] directed_values [DIRECTED_ITEMS] = '{
    32'h0, 32'h0, 32'h0, 32'h0, 32'hDEAD_BEEF, 32'h0,
    VAL_MIN, VAL_MAX, 32'h0, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
    32'h0, 32'h0F0F_0F0F, 32'h1234_5678, 32'h0, 32'h0, 32'h0,
    32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0
  };

  double_ended_queue #(.DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .valid(valid),
    .result(result)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (valid === 1'b1) begin
        tracker.check_result(result);
      end
      if (start && busy === 1'b0) begin
        tracker.note_command(cmd);
      end
    end
  end

  function automatic dq_in_t make_item(logic [OP_W-1:0] op, logic [VAL_W-1:0] v);
    dq_in_t item;
    item.opcode = op;
    item.value = v;
    return item;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic int next_gap();
    return quiet ? 0 : $urandom_range(0, 7);
  endfunction

  task automatic send_item(dq_in_t item, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= item;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    do @(posedge clk); while (tracker.expected_results.size() != 0);
  endtask

  initial begin
    traffic_mode_t mode;
    int at_limit;
    int mixed_left;
    int r;
    int push_pct;
    int pop_pct;
    logic [OP_W-1:0] op;

    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    quiet = 1'b0;
    tracker = new();
    mode = GROW;
    at_limit = 0;
    mixed_left = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_ITEMS; i++) begin
      send_item(make_item(directed_ops[i], directed_values[i]), next_gap());
    end
    wait_for_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 25 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_ITEMS / 2) wait_for_results();

      case (mode)
        GROW: begin
          if (tracker.fill == DEPTH) at_limit++;
          if (at_limit > 4) begin
            mode = SHRINK;
            at_limit = 0;
          end
        end
        SHRINK: begin
          if (tracker.fill == 0) at_limit++;
          if (at_limit > 4) begin
            mode = MIXED;
            at_limit = 0;
            mixed_left = 60;
          end
        end
        default: begin
          mixed_left--;
          if (mixed_left <= 0) mode = GROW;
        end
      endcase

      case (mode)
        GROW: begin
          push_pct = 78;
          pop_pct = 10;
        end
        SHRINK: begin
          push_pct = 10;
          pop_pct = 78;
        end
        default: begin
          push_pct = 44;
          pop_pct = 44;
        end
      endcase

      r = $urandom_range(0, 99);
      if (r < push_pct) begin
        op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      end else if (r < push_pct + pop_pct) begin
        op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
      end else if (r < push_pct + pop_pct + 4) begin
        op = OP_LENGTH;
      end else if (r < push_pct + pop_pct + 9) begin
        op = OP_LIST;
      end else begin
        op = $urandom_range(0, 1) ? OP_BAD_LOW : OP_BAD_HIGH;
      end
      if (mode == GROW && at_limit == 1) op = OP_LIST;

      send_item(make_item(op, pick_value()), next_gap());
    end

    wait_for_results();
    repeat (10) @(posedge clk);

    $display("Sent %0d items; checked %0d results, %0d of them list entries.",
             tracker.items_seen, tracker.checked, tracker.listed);
    $display("Hit %0d full refusals and %0d empty cases; %0d mismatches.",
             tracker.full_refusals, tracker.empty_hits, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out waiting for the block.");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
